// ===== hdl/cbf_pkg.sv =====
// package: types, sizes and control group for the contained box filter
`timescale 1ns / 1ps

package cbf_pkg;

  localparam int MAX_RECTS  = 32;
  localparam int COORD_BITS = 12;
  localparam int CNT_W      = $clog2(MAX_RECTS + 1);
  localparam int ROT_W      = $clog2(MAX_RECTS);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } box_t;

  typedef struct packed {
    coord_t rect_x;
    coord_t rect_y;
    coord_t rect_width;
    coord_t rect_height;
    logic   last_in_set;
  } item_t;

  typedef struct packed {
    coord_t kept_x;
    coord_t kept_y;
    coord_t kept_width;
    coord_t kept_height;
    logic   last_of_run;
    logic   none_found;
    logic   overflow;
  } result_t;

  typedef struct packed {
    logic start;
    logic rotate;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    box_t box;
    logic valid;
  } ring_t;

  typedef struct packed {
    box_t box;
    logic valid;
    logic nested;
  } cell_state_t;

endpackage

// ===== hdl/cbf_cell.sv =====
// one cell: a stored box, its containment flag and a circulating probe box
`timescale 1ns / 1ps

module cbf_cell import cbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_ctrl_t  ctrl,
  input  logic        load,
  input  box_t        load_box,
  input  ring_t       ring_in,
  input  cell_state_t shift_in,
  output ring_t       ring_out,
  output cell_state_t state
);

  box_t box;
  logic valid;
  logic nested;
  box_t rbox;
  logic rvalid;
  logic hit;

  function automatic logic box_within(box_t a, box_t b);
    logic [COORD_BITS:0] ar;
    logic [COORD_BITS:0] ab;
    logic [COORD_BITS:0] br;
    logic [COORD_BITS:0] bb;
    logic                zero_box;
    ar = {1'b0, a.x} + {1'b0, a.w};
    ab = {1'b0, a.y} + {1'b0, a.h};
    br = {1'b0, b.x} + {1'b0, b.w};
    bb = {1'b0, b.y} + {1'b0, b.h};
    zero_box = (a.x == '0) && (a.y == '0) && (a.w == '0) && (a.h == '0);
    return zero_box || ((a.w != '0) && (a.h != '0) && (b.x <= a.x) && (b.y <= a.y) &&
                        (ar <= br) && (ab <= bb));
  endfunction

  assign hit = valid && ring_in.valid && box_within(box, ring_in.box);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      nested <= 1'b0;
      rvalid <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        valid  <= 1'b0;
        nested <= 1'b0;
      end else if (load) begin
        valid <= 1'b1;
        box   <= load_box;
      end else if (ctrl.shift) begin
        box    <= shift_in.box;
        valid  <= shift_in.valid;
        nested <= shift_in.nested;
      end else if (ctrl.start) begin
        nested <= 1'b0;
      end else if (ctrl.rotate && hit) begin
        nested <= 1'b1;
      end
      if (ctrl.start) begin
        rbox   <= box;
        rvalid <= valid;
      end else if (ctrl.rotate) begin
        rbox   <= ring_in.box;
        rvalid <= ring_in.valid;
      end
    end
  end

  assign ring_out.box   = rbox;
  assign ring_out.valid = rvalid;
  assign state.box      = box;
  assign state.valid    = valid;
  assign state.nested   = nested;

endmodule

// ===== hdl/contained_box_filter.sv =====
// top level: cell row, set control and result register of the contained box filter
`timescale 1ns / 1ps

// Boxes are taken one per beat into a row of MAX_RECTS cells. After the beat marked
// last_in_set the row rotates every box past every other cell, each cell flagging its
// own box when it lies wholly inside a passing one; this ring rotation sets the cost,
// and its length is set by MAX_RECTS, not by the set size. The row then shifts toward
// cell 0, one cell per cycle unless a surviving box in cell 0 waits for a free result
// register, putting each surviving box into the result register (or one none_found
// beat). Input is not taken while a set is being filtered. Boxes beyond MAX_RECTS are
// dropped and every result of that set carries overflow.
module contained_box_filter import cbf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_RING  = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_NONE  = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  logic [ROT_W-1:0] rot_cnt;
  logic             dropped;
  logic             emitted;

  cell_ctrl_t       ctrl;
  box_t             in_box;
  logic             accept;
  logic             slot_free;
  logic             emit_box;
  logic             emit_none;
  logic             done;
  logic             any_keep;
  logic             rest_keep;
  logic [MAX_RECTS-1:0] keep;

  ring_t       ring  [MAX_RECTS];
  cell_state_t cst   [MAX_RECTS];
  cell_state_t shsrc [MAX_RECTS];

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign slot_free  = !result_valid || result_ready;

  assign in_box.x = item.rect_x;
  assign in_box.y = item.rect_y;
  assign in_box.w = item.rect_width;
  assign in_box.h = item.rect_height;

  for (genvar g = 0; g < MAX_RECTS; g++) begin : g_cell
    if (g == MAX_RECTS - 1) begin : g_tail
      assign shsrc[g] = '0;
    end else begin : g_body
      assign shsrc[g] = cst[g+1];
    end
    assign keep[g] = cst[g].valid && !cst[g].nested;

    cbf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .load     (accept && (count == CNT_W'(g))),
      .load_box (in_box),
      .ring_in  (ring[(g == 0) ? MAX_RECTS - 1 : g - 1]),
      .shift_in (shsrc[g]),
      .ring_out (ring[g]),
      .state    (cst[g])
    );
  end

  assign any_keep  = |keep;
  assign rest_keep = |keep[MAX_RECTS-1:1];

  always_comb begin
    ctrl      = '0;
    emit_box  = 1'b0;
    emit_none = 1'b0;
    done      = 1'b0;
    case (state)
      ST_START: ctrl.start  = 1'b1;
      ST_RING:  ctrl.rotate = 1'b1;
      ST_EMIT: begin
        if (!any_keep) begin
          done = emitted;
        end else if (keep[0]) begin
          emit_box   = slot_free;
          ctrl.shift = slot_free;
        end else begin
          ctrl.shift = 1'b1;
        end
      end
      ST_NONE: begin
        emit_none = slot_free;
        done      = slot_free;
      end
      default: ctrl = '0;
    endcase
    ctrl.clear = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      rot_cnt      <= '0;
      dropped      <= 1'b0;
      emitted      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (emit_box || emit_none) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (count == CNT_W'(MAX_RECTS)) begin
              dropped <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
            if (item.last_in_set) begin
              state <= ST_START;
            end
          end
        end
        ST_START: begin
          rot_cnt <= '0;
          state   <= ST_RING;
        end
        ST_RING: begin
          rot_cnt <= rot_cnt + ROT_W'(1);
          if (rot_cnt == ROT_W'(MAX_RECTS - 2)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_box) begin
            emitted <= 1'b1;
          end
          if (!any_keep) begin
            state <= emitted ? ST_IDLE : ST_NONE;
          end
        end
        ST_NONE: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (done) begin
        count   <= '0;
        dropped <= 1'b0;
        emitted <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_box) begin
      result.kept_x      <= cst[0].box.x;
      result.kept_y      <= cst[0].box.y;
      result.kept_width  <= cst[0].box.w;
      result.kept_height <= cst[0].box.h;
      result.last_of_run <= !rest_keep;
      result.none_found  <= 1'b0;
      result.overflow    <= dropped;
    end else if (emit_none) begin
      result.kept_x      <= '0;
      result.kept_y      <= '0;
      result.kept_width  <= '0;
      result.kept_height <= '0;
      result.last_of_run <= 1'b1;
      result.none_found  <= 1'b1;
      result.overflow    <= dropped;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RECTS))
    else $error("box count beyond capacity");

  a_none_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.none_found |-> result.last_of_run &&
      (result.kept_width == '0) && (result.kept_height == '0))
    else $error("none_found beat not final or not zero");

  a_no_input_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) || (state == ST_RING) |-> !item_ready)
    else $error("input taken while filtering");

  a_emit_kept: assert property (@(posedge clk) disable iff (rst)
    emit_box |=> result_valid && !result.none_found)
    else $error("survivor beat lost");

endmodule
